// ----- hdl/sinp_pkg.sv -----
package sinp_pkg;

  // Field and stream widths.
  localparam int ANGLE_W = 18;
  localparam int OUT_W   = 18;
  localparam int TDATA_W = 24;

  // Intermediate widths, sized for |angle| up to 2^17 in Q.15.
  localparam int MAG_W  = 18;   // |angle|, up to 131072
  localparam int S_W    = 20;   // x^2, up to 2^19
  localparam int T_W    = 24;   // x^4, up to 2^23
  localparam int P3_W   = 22;   // x^3, up to 2^21
  localparam int P5_W   = 26;   // x^5, up to 2^25
  localparam int C1M_W  = 35;
  localparam int C3P_W  = 36;
  localparam int C5P_W  = 35;
  localparam int DS_W   = 32;
  localparam int DT_W   = 30;
  localparam int NUM_W  = 38;   // signed numerator
  localparam int DEN_W  = 34;   // denominator, below 2^34
  localparam int FRAC_SHIFT = 15;

  // Quotient: |num| * 2^16 / den stays below 2^20.
  localparam int FRAC_OUT = 16;
  localparam int QUO_W    = 20;

  // Polynomial coefficients.
  localparam int NUM_C1 = 166320;
  localparam int NUM_C3 = 22260;
  localparam int NUM_C5 = 551;
  localparam int DEN_C0 = 166320;
  localparam int DEN_C2 = 5460;
  localparam int DEN_C4 = 75;

  // Pipeline shape.
  localparam int POLY_STAGES    = 6;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    neg;
  } poly_out_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             neg;
  } div_out_t;

endpackage

// ----- hdl/sinp_poly.sv -----
module sinp_poly (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sinp_pkg::ANGLE_W-1:0]  angle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sinp_pkg::poly_out_t           out_o
);
  import sinp_pkg::*;

  logic [POLY_STAGES-1:0] vld_q;
  logic [POLY_STAGES-1:0] adv;

  // Stage 0: magnitude and sign.
  logic [MAG_W-1:0] m0_d, m0_q;
  logic             neg0_q;
  // Stage 1: x^2.
  logic [2*MAG_W-1:0] mm;
  logic [S_W-1:0]     s1_d, s1_q;
  logic [MAG_W-1:0]   m1_q;
  logic               neg1_q;
  // Stage 2: x^4 and x^3.
  logic [2*S_W-1:0]     ss;
  logic [S_W+MAG_W-1:0] sm;
  logic [T_W-1:0]       t2_d, t2_q;
  logic [P3_W-1:0]      p3_2_d, p3_2_q;
  logic [S_W-1:0]       s2_q;
  logic [MAG_W-1:0]     m2_q;
  logic                 neg2_q;
  // Stage 3: x^5 and the coefficient products.
  logic [T_W+MAG_W-1:0] tm;
  logic [P5_W-1:0]      p5_3_d, p5_3_q;
  logic [C1M_W-1:0]     c1m3_d, c1m3_q;
  logic [C3P_W-1:0]     c3p3_d, c3p3_q;
  logic [DS_W-1:0]      ds3_d, ds3_q;
  logic [DT_W-1:0]      dt3_d, dt3_q;
  logic                 neg3_q;
  // Stage 4: partial numerator and full denominator.
  logic [C5P_W-1:0]        c5p4_d, c5p4_q;
  logic signed [NUM_W-1:0] npart4_d, npart4_q;
  logic [DEN_W-1:0]        den4_d, den4_q;
  logic                    neg4_q;
  // Stage 5: numerator.
  logic signed [NUM_W-1:0] num5_d, num5_q;
  logic [DEN_W-1:0]        den5_q;
  logic                    neg5_q;

  always_comb begin
    adv[POLY_STAGES-1] = !vld_q[POLY_STAGES-1] || out_ready_i;
    for (int k = POLY_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[POLY_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < POLY_STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // The most negative angle maps to 2^17, which still fits unsigned.
  assign m0_d = angle_i[ANGLE_W-1] ? (~angle_i + 1'b1) : angle_i;

  assign mm   = (2*MAG_W)'(m0_q) * (2*MAG_W)'(m0_q);
  assign s1_d = mm[FRAC_SHIFT +: S_W];

  assign ss     = (2*S_W)'(s1_q) * (2*S_W)'(s1_q);
  assign t2_d   = ss[FRAC_SHIFT +: T_W];
  assign sm     = (S_W+MAG_W)'(s1_q) * (S_W+MAG_W)'(m1_q);
  assign p3_2_d = sm[FRAC_SHIFT +: P3_W];

  assign tm     = (T_W+MAG_W)'(t2_q) * (T_W+MAG_W)'(m2_q);
  assign p5_3_d = tm[FRAC_SHIFT +: P5_W];
  assign c1m3_d = C1M_W'(m2_q) * C1M_W'(NUM_C1);
  assign c3p3_d = C3P_W'(p3_2_q) * C3P_W'(NUM_C3);
  assign ds3_d  = DS_W'(s2_q) * DS_W'(DEN_C2);
  assign dt3_d  = DT_W'(t2_q) * DT_W'(DEN_C4);

  assign c5p4_d   = C5P_W'(p5_3_q) * C5P_W'(NUM_C5);
  assign npart4_d = $signed(NUM_W'(c1m3_q)) - $signed(NUM_W'(c3p3_q));
  assign den4_d   = (DEN_W'(DEN_C0) << FRAC_SHIFT) + DEN_W'(ds3_q) + DEN_W'(dt3_q);

  assign num5_d = npart4_q + $signed(NUM_W'(c5p4_q));

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      m0_q   <= m0_d;
      neg0_q <= angle_i[ANGLE_W-1];
    end
    if (adv[1] && vld_q[0]) begin
      m1_q   <= m0_q;
      s1_q   <= s1_d;
      neg1_q <= neg0_q;
    end
    if (adv[2] && vld_q[1]) begin
      m2_q   <= m1_q;
      s2_q   <= s1_q;
      t2_q   <= t2_d;
      p3_2_q <= p3_2_d;
      neg2_q <= neg1_q;
    end
    if (adv[3] && vld_q[2]) begin
      p5_3_q <= p5_3_d;
      c1m3_q <= c1m3_d;
      c3p3_q <= c3p3_d;
      ds3_q  <= ds3_d;
      dt3_q  <= dt3_d;
      neg3_q <= neg2_q;
    end
    if (adv[4] && vld_q[3]) begin
      c5p4_q   <= c5p4_d;
      npart4_q <= npart4_d;
      den4_q   <= den4_d;
      neg4_q   <= neg3_q;
    end
    if (adv[5] && vld_q[4]) begin
      num5_q <= num5_d;
      den5_q <= den4_q;
      neg5_q <= neg4_q;
    end
  end

  assign out_o.num = num5_q;
  assign out_o.den = den5_q;
  assign out_o.neg = neg5_q;

endmodule

// ----- hdl/sinp_div.sv -----
module sinp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sinp_pkg::poly_out_t in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sinp_pkg::div_out_t  out_o
);
  import sinp_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] low;
    logic [QUO_W-1:0] quo;
    logic [DEN_W-1:0] den;
    logic             neg;
  } div_stage_t;

  localparam int NSTG = DIV_STAGES + 1;

  div_stage_t       stg_d [NSTG];
  div_stage_t       stg_q [NSTG];
  logic [NSTG-1:0]  vld_q;
  logic [NSTG-1:0]  adv;
  logic [NUM_W-1:0] mag;

  always_comb begin
    adv[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NSTG-1];

  assign mag = in_i.num[NUM_W-1] ? NUM_W'(-in_i.num) : NUM_W'(in_i.num);

  // Entry stage takes magnitudes and sign. The top bits of |num| * 2^16 are already
  // below den because the quotient fits in QUO_W bits. The later stages run a
  // restoring division, BITS_PER_STAGE quotient bits per stage.
  always_comb begin
    div_stage_t       cur;
    logic [DEN_W:0]   trial;
    stg_d[0].rem = DEN_W'(mag >> (QUO_W - FRAC_OUT));
    stg_d[0].low = QUO_W'(mag << FRAC_OUT);
    stg_d[0].quo = '0;
    stg_d[0].den = in_i.den;
    stg_d[0].neg = in_i.neg ^ in_i.num[NUM_W-1];
    for (int k = 1; k < NSTG; k++) begin
      cur = stg_q[k-1];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        trial = {cur.rem, cur.low[QUO_W-1]};
        cur.low = cur.low << 1;
        if (trial >= {1'b0, cur.den}) begin
          cur.rem = DEN_W'(trial - {1'b0, cur.den});
          cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
        end else begin
          cur.rem = DEN_W'(trial);
          cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
        end
      end
      stg_d[k] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      stg_q[0] <= stg_d[0];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (adv[k] && vld_q[k-1]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign out_o.quo = stg_q[NSTG-1].quo;
  assign out_o.neg = stg_q[NSTG-1].neg;

endmodule

// ----- hdl/sine_pade_rational_approx.sv -----
// Sine from the [5/4] Pade approximant, Q2.15 angle in, saturated Q1.16 out.
// Throughput: one item per cycle unless the output stalls; six polynomial stages feed
// an eleven-stage divider whose entry stage aligns |num| and whose later stages each
// retire two quotient bits in a restoring division, then one output stage.
// Reset clears every valid bit at once; no item is held across reset.
module sine_pade_rational_approx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata bits from the lowest up: angle [17:0], zero padding [23:18].
  input  logic [sinp_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata bits from the lowest up: sine_value [17:0], zero padding [23:18].
  output logic [sinp_pkg::TDATA_W-1:0]  m_axis_tdata_o
);
  import sinp_pkg::*;

  localparam logic [QUO_W-1:0] POS_LIMIT = QUO_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1 << (OUT_W - 1));
  localparam logic [OUT_W-1:0] OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN   = {1'b1, {(OUT_W-1){1'b0}}};

  poly_out_t        poly_out;
  logic             poly_valid;
  logic             poly_ready;
  div_out_t         div_out;
  logic             div_valid;
  logic             div_ready;
  logic             out_load;
  logic             out_vld_q;
  logic [OUT_W-1:0] out_d, out_q;

  sinp_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .angle_i     (s_axis_tdata_i[ANGLE_W-1:0]),
    .out_valid_o (poly_valid),
    .out_ready_i (poly_ready),
    .out_o       (poly_out)
  );

  sinp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poly_valid),
    .in_ready_o  (poly_ready),
    .in_i        (poly_out),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_out)
  );

  assign div_ready = !out_vld_q || m_axis_tready_i;
  assign out_load  = div_valid && div_ready;

  // Apply the sign and clamp to the 18-bit signed range.
  always_comb begin
    if (div_out.neg) begin
      if (div_out.quo >= NEG_LIMIT) begin
        out_d = OUT_MIN;
      end else begin
        out_d = ~div_out.quo[OUT_W-1:0] + 1'b1;
      end
    end else begin
      if (div_out.quo > POS_LIMIT) begin
        out_d = OUT_MAX;
      end else begin
        out_d = div_out.quo[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (div_ready) begin
      out_vld_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(TDATA_W-OUT_W){1'b0}}, out_q};

  // The input side stalls only when every stage is full and the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled while the pipeline has room");

  // A zero quotient must come out as zero whatever its sign.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && div_out.quo == '0) |=> (m_axis_tdata_o[OUT_W-1:0] == '0))
    else $error("zero quotient gave a nonzero result");

  // A positive quotient beyond range must saturate to the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !div_out.neg && div_out.quo > POS_LIMIT)
      |=> (m_axis_tdata_o[OUT_W-1:0] == OUT_MAX))
    else $error("positive overflow did not saturate");

endmodule

// ----- tb/sine_checker.sv -----
module sine_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  // tdata bits from the lowest up: angle [17:0], zero padding [23:18].
  input  logic [sinp_pkg::TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  // tdata bits from the lowest up: sine_value [17:0], zero padding [23:18].
  input  logic [sinp_pkg::TDATA_W-1:0]  m_axis_tdata_i,
  output int                            fail_count_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sinp_pkg::*;

  localparam int PRINT_CAP = 100;

  logic [OUT_W-1:0] expected_sine[$];
  int               sine_index;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
    sine_index    = 0;
  end

  // Odd rational approximant on |angle|, sign applied after the division.
  function automatic logic [OUT_W-1:0] predict_sine(logic [ANGLE_W-1:0] angle);
    longint mag;
    longint sq;
    longint quad;
    longint cube;
    longint fifth;
    longint num;
    longint den;
    longint quo;
    logic   neg;
    neg   = angle[ANGLE_W-1];
    mag   = neg ? (longint'(1) << ANGLE_W) - longint'(angle) : longint'(angle);
    sq    = (mag * mag) >>> FRAC_SHIFT;
    quad  = (sq * sq) >>> FRAC_SHIFT;
    cube  = (sq * mag) >>> FRAC_SHIFT;
    fifth = (quad * mag) >>> FRAC_SHIFT;
    num   = longint'(NUM_C1) * mag - longint'(NUM_C3) * cube + longint'(NUM_C5) * fifth;
    den   = (longint'(DEN_C0) << FRAC_SHIFT) + longint'(DEN_C2) * sq
          + longint'(DEN_C4) * quad;
    quo   = (num * (longint'(1) << FRAC_OUT)) / den;
    if (neg) begin
      quo = -quo;
    end
    if (quo > longint'((1 << (OUT_W - 1)) - 1)) begin
      quo = (1 << (OUT_W - 1)) - 1;
    end
    if (quo < -longint'(1 << (OUT_W - 1))) begin
      quo = -longint'(1 << (OUT_W - 1));
    end
    return quo[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count_o < PRINT_CAP) begin
      $display("[%0t] sine result %0d: %s", $realtime, sine_index, what);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // Retire the output transfer before queuing a new angle, so a result can
      // never be matched against an angle accepted in the same cycle.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_sine.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, tdata %h", m_axis_tdata_i));
        end else begin
          logic [OUT_W-1:0] want;
          want = expected_sine.pop_front();
          if (m_axis_tdata_i[OUT_W-1:0] !== want) begin
            report_mismatch($sformatf("sine_value %0d, expected %0d",
                                      $signed(m_axis_tdata_i[OUT_W-1:0]), $signed(want)));
          end
          if (m_axis_tdata_i[TDATA_W-1:OUT_W] !== '0) begin
            report_mismatch($sformatf("padding bits %b not zero",
                                      m_axis_tdata_i[TDATA_W-1:OUT_W]));
          end
        end
        sine_index++;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_sine.push_back(predict_sine(s_axis_tdata_i[ANGLE_W-1:0]));
      end
      outstanding_o <= expected_sine.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sinp_pkg::*;

  localparam int RANDOM_ANGLES = 2000;
  localparam int DRAIN_CYCLES  = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  int                 fail_count;
  int                 outstanding;

  // Receiver stall regime and how long it lasts.
  int                 stall_mode;
  int                 stall_left;

  sine_pade_rational_approx dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  sine_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    stall_mode = 0;
    stall_left = 0;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // Holds one angle on the slave side until its transfer; returns at that edge.
  task automatic send_angle(logic [ANGLE_W-1:0] angle);
    logic taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W - ANGLE_W){1'b0}}, angle};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Random angle, weighted toward zero and toward both ends of the range.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      return ANGLE_W'($urandom_range(0, (1 << ANGLE_W) - 1));
    end else if (kind < 8) begin
      return ANGLE_W'($urandom_range(0, 255) - 128);
    end else begin
      return ANGLE_W'((1 << (ANGLE_W - 1)) + $urandom_range(0, 511) - 256);
    end
  endfunction

  logic [ANGLE_W-1:0] directed_angles[$] = '{
    18'd0, 18'd1, -18'sd1, 18'd131071, -18'sd131072, -18'sd131071,
    18'd32768, -18'sd32768, 18'd51472, -18'sd51472, 18'd102944, -18'sd102944,
    18'd65536, -18'sd65536, 18'd98304, -18'sd98304, 18'd16384, -18'sd16384,
    18'h15555, 18'h2AAAA, 18'd100, -18'sd100
  };

  initial begin
    int sent;
    int burst;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_angles[i]) begin
      send_angle(directed_angles[i]);
    end
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 30)) @(posedge clk_i);

    sent = 0;
    while (sent < RANDOM_ANGLES) begin
      burst = $urandom_range(1, 60);
      for (int k = 0; k < burst && sent < RANDOM_ANGLES; k++) begin
        send_angle(pick_angle());
        sent++;
      end
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end

    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sinp_pkg.sv
hdl/sinp_poly.sv
hdl/sinp_div.sv
hdl/sine_pade_rational_approx.sv
tb/sine_checker.sv
tb/tb.sv
